// ===== rtl/core/tagged_ascii_response_parser_defines.svh =====
// Assertion macros shared by the parser RTL.
`ifndef TAGGED_ASCII_RESPONSE_PARSER_DEFINES_SVH
`define TAGGED_ASCII_RESPONSE_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TARP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("parser check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define TARP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("parser check failed one cycle later");

`endif

// ===== rtl/core/tarp_pkg.sv =====
`default_nettype none

package tarp_pkg;

    localparam int MAX_PAYLOAD_DEFAULT = 31;

    localparam logic [7:0]  CH_STX  = 8'h02;
    localparam logic [7:0]  CH_EOT  = 8'h04;
    localparam logic [7:0]  CH_PLUS = 8'h2B;
    localparam logic [7:0]  CH_MINUS = 8'h2D;
    localparam logic [7:0]  CH_SPACE = 8'h20;
    localparam logic [23:0] TAG_NAC = {8'h4E, 8'h41, 8'h43};

    // Magnitude limit of the accumulator, the magnitude of the most negative int32.
    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

    localparam logic [2:0] ST_VALUE     = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_NACK      = 3'd2;
    localparam logic [2:0] ST_UNKNOWN   = 3'd3;
    localparam logic [2:0] ST_TRUNCATED = 3'd4;
    localparam logic [2:0] ST_OVERLONG  = 3'd5;

    typedef enum logic [3:0] {
        PH_SCAN    = 4'b0001,
        PH_TAG     = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_NACK    = 4'b1000
    } phase_t;

    typedef enum logic [3:0] {
        NP_WS     = 4'b0001,
        NP_SIGN   = 4'b0010,
        NP_DIGITS = 4'b0100,
        NP_DONE   = 4'b1000
    } num_phase_t;

endpackage

`default_nettype wire

// ===== rtl/core/tagged_ascii_response_parser.sv =====
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  rx_byte[7:0], buffer_end
// output    out        out_valid/out_stall  status[2:0], value[31:0] signed
// config    in         cfg_we               cfg_wdata[23:0] (expected tag)
//
// One byte is taken every cycle while in_stall is low; it passes through the byte register
// and then the result register, from which the result transfers when out_stall is low.
// The byte is registered first, then the parser state and the result register update
// together, so the accumulate step (times ten plus a digit, with saturation) sets the path.
// Reset clears the parser to scanning for STX and the expected tag to zero.
// A stalled result holds the byte register, and in_stall rises only while both stages are full.
`default_nettype none
`include "tagged_ascii_response_parser_defines.svh"

module tagged_ascii_response_parser #(
    parameter int MAX_PAYLOAD = tarp_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [23:0]        cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               buffer_end,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              status,
    output logic signed [31:0]      value
);
    import tarp_pkg::*;

    // The length counter must reach MAX_PAYLOAD itself.
    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

    logic [23:0]       exp_tag_reg;

    // Input stage.
    logic              s1_valid_reg;
    logic [7:0]        s1_byte_reg;
    logic              s1_end_reg;

    // Parser state.
    phase_t            phase_reg, phase_next;
    logic [23:0]       tag_reg, tag_next;
    logic [1:0]        tag_cnt_reg, tag_cnt_next;
    logic [31:0]       acc_reg, acc_next;
    logic              neg_reg, neg_next;
    num_phase_t        np_reg, np_next;
    logic [LEN_W-1:0]  len_reg, len_next;

    // Result stage.
    logic              out_valid_reg;
    logic [2:0]        status_reg, status_next;
    logic [31:0]       value_reg, value_next;
    logic              emit;

    logic              out_free;
    logic              s1_fire;

    // The result register is free when it is empty or its result is taken this cycle.
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value     = value_reg;

    logic              is_digit;
    logic              is_ws;
    logic [35:0]       acc_prod;

    assign is_digit = (s1_byte_reg >= 8'h30) && (s1_byte_reg <= 8'h39);
    assign is_ws    = (s1_byte_reg == CH_SPACE) ||
                      ((s1_byte_reg >= 8'h09) && (s1_byte_reg <= 8'h0D));
    // Times ten as two shifts, plus the digit.
    assign acc_prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                    + {32'd0, s1_byte_reg[3:0]};

    always_comb
    begin
        logic consumed;
        num_phase_t np_tmp;

        phase_next   = phase_reg;
        tag_next     = tag_reg;
        tag_cnt_next = tag_cnt_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        np_next      = np_reg;
        len_next     = len_reg;
        emit         = 1'b0;
        status_next  = ST_VALUE;
        value_next   = 32'd0;
        consumed     = 1'b0;
        np_tmp       = np_reg;

        unique case (phase_reg)
            PH_SCAN:
            begin
                if (s1_byte_reg == CH_STX)
                begin
                    if (s1_end_reg)
                    begin
                        emit        = 1'b1;
                        status_next = ST_TRUNCATED;
                    end
                    else
                    begin
                        phase_next   = PH_TAG;
                        tag_next     = 24'd0;
                        tag_cnt_next = 2'd0;
                    end
                end
            end
            PH_TAG:
            begin
                tag_next     = {tag_reg[15:0], s1_byte_reg};
                tag_cnt_next = tag_cnt_reg + 2'd1;
                if (tag_cnt_reg < 2'd2)
                begin
                    if (s1_end_reg)
                    begin
                        emit        = 1'b1;
                        status_next = ST_TRUNCATED;
                    end
                end
                else
                begin
                    tag_cnt_next = 2'd0;
                    // The configured tag wins over NAC when both match.
                    priority if (tag_next == exp_tag_reg)
                        phase_next = PH_PAYLOAD;
                    else if (tag_next == TAG_NAC)
                        phase_next = PH_NACK;
                    else
                    begin
                        emit        = 1'b1;
                        status_next = ST_UNKNOWN;
                    end
                    if (!emit && s1_end_reg)
                    begin
                        emit        = 1'b1;
                        status_next = ST_TRUNCATED;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                if (s1_byte_reg == CH_EOT)
                begin
                    emit = 1'b1;
                    if (len_reg == '0)
                        status_next = ST_EMPTY;
                    else
                    begin
                        status_next = ST_VALUE;
                        // A single-character payload always reads as zero.
                        if (len_reg < LEN_W'(2))
                            value_next = 32'd0;
                        else if (neg_reg)
                            value_next = 32'd0 - acc_reg;
                        else if (acc_reg >= MAG_LIMIT)
                            value_next = POS_MAX;
                        else
                            value_next = acc_reg;
                    end
                end
                else if (len_reg >= LEN_W'(MAX_PAYLOAD))
                begin
                    emit        = 1'b1;
                    status_next = ST_OVERLONG;
                end
                else
                begin
                    len_next = len_reg + LEN_W'(1);
                    if (np_reg == NP_WS)
                    begin
                        if (is_ws)
                            consumed = 1'b1;
                        else if ((s1_byte_reg == CH_PLUS) || (s1_byte_reg == CH_MINUS))
                        begin
                            neg_next = (s1_byte_reg == CH_MINUS);
                            np_tmp   = NP_SIGN;
                            consumed = 1'b1;
                        end
                        else
                            np_tmp = NP_DIGITS;
                    end
                    else if (np_reg == NP_SIGN)
                        np_tmp = NP_DIGITS;

                    if (!consumed && (np_tmp == NP_DIGITS))
                    begin
                        if (!is_digit)
                            np_tmp = NP_DONE;
                        else if (acc_prod > {4'd0, MAG_LIMIT})
                            acc_next = MAG_LIMIT;
                        else
                            acc_next = acc_prod[31:0];
                    end
                    np_next = np_tmp;

                    if (s1_end_reg)
                    begin
                        emit        = 1'b1;
                        status_next = ST_TRUNCATED;
                    end
                end
            end
            PH_NACK:
            begin
                if (s1_byte_reg == CH_EOT)
                begin
                    emit        = 1'b1;
                    status_next = ST_NACK;
                end
                else if (s1_end_reg)
                begin
                    emit        = 1'b1;
                    status_next = ST_TRUNCATED;
                end
            end
            default:
            begin
                phase_next = PH_SCAN;
            end
        endcase

        // Every result, and any unexpected phase code, sends the parser back to scanning.
        if (emit || (phase_next == PH_SCAN))
        begin
            phase_next   = PH_SCAN;
            tag_next     = 24'd0;
            tag_cnt_next = 2'd0;
            acc_next     = 32'd0;
            neg_next     = 1'b0;
            np_next      = NP_WS;
            len_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_tag_reg   <= 24'd0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_SCAN;
            tag_reg       <= 24'd0;
            tag_cnt_reg   <= 2'd0;
            acc_reg       <= 32'd0;
            neg_reg       <= 1'b0;
            np_reg        <= NP_WS;
            len_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
                exp_tag_reg <= cfg_wdata;

            if (!in_stall)
                s1_valid_reg <= in_valid;

            if (s1_fire)
            begin
                phase_reg   <= phase_next;
                tag_reg     <= tag_next;
                tag_cnt_reg <= tag_cnt_next;
                acc_reg     <= acc_next;
                neg_reg     <= neg_next;
                np_reg      <= np_next;
                len_reg     <= len_next;
            end

            if (out_free)
                out_valid_reg <= s1_fire && emit;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_byte_reg <= rx_byte;
            s1_end_reg  <= buffer_end;
        end
        if (s1_fire && emit)
        begin
            status_reg <= status_next;
            value_reg  <= value_next;
        end
    end

    `TARP_ASSERT_SAME(a_stall_only_when_full, clk, rst_n,
        in_stall, s1_valid_reg && out_valid_reg)
    `TARP_ASSERT_SAME(a_value_only_with_number, clk, rst_n,
        out_valid && (status != ST_VALUE), value == 32'sd0)
    `TARP_ASSERT_NEXT(a_result_returns_to_scan, clk, rst_n,
        s1_fire && emit, out_valid && (phase_reg == PH_SCAN) && (len_reg == '0))
    `TARP_ASSERT_SAME(a_length_bounded, clk, rst_n,
        1'b1, len_reg <= LEN_W'(MAX_PAYLOAD))

endmodule

`default_nettype wire
